// ----- rtl/arx_cipher_round_step_unit_macros.svh -----
// assertion macros for the arx round step unit
// every macro samples on clk_i and is switched off while rst_ni is low
`ifndef ARX_CIPHER_ROUND_STEP_UNIT_MACROS_SVH
`define ARX_CIPHER_ROUND_STEP_UNIT_MACROS_SVH

`ifndef SYNTH

// property that must hold on every edge out of reset
`define ARX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that the left side implies the right side on the next edge
`define ARX_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`else

`define ARX_ASSERT(lbl, prop, msg)
`define ARX_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// ----- rtl/arx_pkg.sv -----
`timescale 1ns / 1ps

package arx_pkg;

  localparam int unsigned ARX_ROWS = 9;
  localparam int unsigned ARX_COLS = 4;

  localparam logic [3:0] ARX_LAST_ROW = 4'(ARX_ROWS - 1);

  typedef enum logic {
    FUNC_ENC = 1'b0,
    FUNC_DEC = 1'b1
  } arx_func_e;

  typedef struct packed {
    logic [3:0]  round_index;
    logic [1:0]  step_index;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [15:0] word_d;
    logic [15:0] round_key;
    arx_func_e   func;
  } arx_req_t;

  typedef struct packed {
    logic [15:0] out_a;
    logic [15:0] out_b;
    logic [15:0] out_c;
    logic [15:0] out_d;
  } arx_res_t;

  // per round and step: additive constant
  localparam logic [15:0] ARX_CONST [ARX_ROWS][ARX_COLS] = '{
    '{16'hAC25, 16'h8A93, 16'h243D, 16'h262E},
    '{16'hF887, 16'hC4F2, 16'h8E36, 16'h9FA1},
    '{16'h7DC0, 16'h6A29, 16'h6D84, 16'h34BD},
    '{16'hA267, 16'hCC15, 16'h04FE, 16'hB94A},
    '{16'hDF24, 16'h40EF, 16'h96DA, 16'h905F},
    '{16'hD631, 16'hAA62, 16'h4D15, 16'h70CB},
    '{16'h7533, 16'h45FC, 16'h5337, 16'hD25E},
    '{16'hA926, 16'h1C7B, 16'h5F12, 16'h4ECC},
    '{16'h3C86, 16'h28DB, 16'hFC01, 16'h7CB1}
  };

  // right rotate amount, always 1..15
  localparam logic [3:0] ARX_ROT [ARX_ROWS][ARX_COLS] = '{
    '{4'd4,  4'd7,  4'd11, 4'd8},
    '{4'd7,  4'd14, 4'd5,  4'd4},
    '{4'd8,  4'd2,  4'd9,  4'd4},
    '{4'd13, 4'd1,  4'd14, 4'd6},
    '{4'd7,  4'd12, 4'd5,  4'd1},
    '{4'd2,  4'd4,  4'd12, 4'd3},
    '{4'd9,  4'd2,  4'd11, 4'd13},
    '{4'd12, 4'd3,  4'd6,  4'd11},
    '{4'd7,  4'd15, 4'd4,  4'd14}
  };

  // 1 selects and, 0 selects or
  localparam logic ARX_AND [ARX_ROWS][ARX_COLS] = '{
    '{1'b1, 1'b0, 1'b1, 1'b0},
    '{1'b0, 1'b0, 1'b0, 1'b0},
    '{1'b1, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b1},
    '{1'b1, 1'b1, 1'b1, 1'b0},
    '{1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b1, 1'b0, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b1, 1'b0}
  };

endpackage

// ----- rtl/arx_step_core.sv -----
`timescale 1ns / 1ps

module arx_step_core (
  input  arx_pkg::arx_req_t req_i,
  output arx_pkg::arx_res_t res_o
);
  import arx_pkg::*;

  logic [3:0]  row;
  logic [1:0]  col;
  logic [15:0] step_key;
  logic [3:0]  rot;
  logic        use_and;
  logic [15:0] enc_sum;
  logic [31:0] enc_rot;
  logic [15:0] enc_c;
  logic [15:0] enc_a;
  logic [31:0] dec_rot;
  logic [15:0] dec_c;
  logic [15:0] dec_a;
  logic [15:0] dec_mix;

  // rounds past the table reuse the last row
  assign row = (req_i.round_index > ARX_LAST_ROW) ? ARX_LAST_ROW : req_i.round_index;
  assign col = req_i.step_index;

  assign step_key = req_i.round_key + ARX_CONST[row][col];
  assign rot      = ARX_ROT[row][col];
  assign use_and  = ARX_AND[row][col];

  // forward: c' = rotr(b + (c ^ k)), a' = a + (c' op d)
  assign enc_sum = req_i.word_b + (req_i.word_c ^ step_key);
  assign enc_rot = {enc_sum, enc_sum} >> rot;
  assign enc_c   = enc_rot[15:0];
  assign enc_a   = req_i.word_a + (use_and ? (enc_c & req_i.word_d)
                                           : (enc_c | req_i.word_d));

  // inverse: a' = a - (c op d), c' = (rotl(c) - b) ^ k
  assign dec_mix = use_and ? (req_i.word_c & req_i.word_d) : (req_i.word_c | req_i.word_d);
  assign dec_a   = req_i.word_a - dec_mix;
  assign dec_rot = {req_i.word_c, req_i.word_c} << rot;
  assign dec_c   = (dec_rot[31:16] - req_i.word_b) ^ step_key;

  always_comb begin
    res_o.out_b = req_i.word_b;
    res_o.out_d = req_i.word_d;
    case (req_i.func)
      FUNC_ENC: begin
        res_o.out_a = enc_a;
        res_o.out_c = enc_c;
      end
      FUNC_DEC: begin
        res_o.out_a = dec_a;
        res_o.out_c = dec_c;
      end
      default: begin
        res_o.out_a = enc_a;
        res_o.out_c = enc_c;
      end
    endcase
  end

endmodule

// ----- rtl/arx_cipher_round_step_unit.sv -----
`timescale 1ns / 1ps

// arx round step unit: applies one sub-step of a four-word 16-bit
// add-rotate-xor cipher, forward (tuser = 0) or inverse (tuser = 1), to each
// input beat. round and step select a constant, a rotate amount and an and/or
// choice from a fixed 9 x 4 table; round indexes above 8 use the last row.
// words b and d pass through. one beat is taken every cycle while tready is high; an
// accepted beat passes the input register, then the result register behind one
// pass of add, xor and rotate logic, before it is presented on the master side.
// both registers hold their beat under back-pressure, so the slave side keeps
// taking beats as long as the input stage is empty or the result register can
// move. no state is kept between beats and reset only clears the valid flags.

`include "arx_cipher_round_step_unit_macros.svh"

module arx_cipher_round_step_unit (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // round_index[3:0], step_index[5:4], word_a[21:6], word_b[37:22],
  // word_c[53:38], word_d[69:54], round_key[85:70], zero pad[87:86]
  input  logic [87:0] s_axis_tdata_i,
  // func[0]: 0 encrypt, 1 decrypt
  input  logic        s_axis_tuser_i,

  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // out_a[15:0], out_b[31:16], out_c[47:32], out_d[63:48]
  output logic [63:0] m_axis_tdata_o
);
  import arx_pkg::*;

  arx_req_t in_req_d, in_req_q;
  logic     in_valid_d, in_valid_q;
  arx_res_t out_res_d, out_res_q;
  logic     out_valid_d, out_valid_q;

  logic     s_beat;
  logic     out_free;
  logic     advance;

  // result register can take a new beat when empty or draining this cycle
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign advance  = in_valid_q && out_free;

  assign s_axis_tready_o = !in_valid_q || out_free;
  assign s_beat          = s_axis_tvalid_i && s_axis_tready_o;

  // unpack the slave beat
  always_comb begin
    in_req_d             = in_req_q;
    if (s_beat) begin
      in_req_d.round_index = s_axis_tdata_i[3:0];
      in_req_d.step_index  = s_axis_tdata_i[5:4];
      in_req_d.word_a      = s_axis_tdata_i[21:6];
      in_req_d.word_b      = s_axis_tdata_i[37:22];
      in_req_d.word_c      = s_axis_tdata_i[53:38];
      in_req_d.word_d      = s_axis_tdata_i[69:54];
      in_req_d.round_key   = s_axis_tdata_i[85:70];
      in_req_d.func        = arx_func_e'(s_axis_tuser_i);
    end
  end

  // input stage holds while the result register is blocked
  assign in_valid_d  = s_beat || (in_valid_q && !out_free);
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready_i);

  arx_res_t core_res;

  arx_step_core u_core (
    .req_i (in_req_q),
    .res_o (core_res)
  );

  assign out_res_d = advance ? core_res : out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    in_req_q  <= in_req_d;
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_res_q.out_d, out_res_q.out_c,
                            out_res_q.out_b, out_res_q.out_a};

  // an accepted beat always lands in the input stage
  `ARX_ASSERT_NEXT(a_accept_loads, s_beat, in_valid_q, "accepted beat lost at input stage")
  // a beat moving forward shows up on the master side
  `ARX_ASSERT_NEXT(a_advance_out, advance, m_axis_tvalid_o, "advanced beat missing at output")
  // a blocked input stage keeps its beat
  `ARX_ASSERT_NEXT(a_in_hold, in_valid_q && !out_free, in_valid_q && $stable(in_req_q),
                   "blocked input stage dropped or changed its beat")
  // pass-through word follows the beat into the result register
  `ARX_ASSERT_NEXT(a_pass_b, advance, out_res_q.out_b == $past(in_req_q.word_b),
                   "word b altered on the way through")

endmodule
